// ===== hdl/bdcc_pkg.sv =====
// shared constants and types for the button debounce and click classifier
`default_nettype none

package bdcc_pkg;

  // config register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE   = 2'd1,
    REG_LONG     = 2'd2
  } reg_index_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  // register reset values
  localparam logic [CfgDataWidth-1:0] DebounceReset = 16'd40;
  localparam logic [CfgDataWidth-1:0] DoubleReset   = 16'd300;
  localparam logic [CfgDataWidth-1:0] LongReset     = 16'd1000;

  // press count saturates here
  localparam int unsigned ClickWidth = 4;
  localparam logic [ClickWidth-1:0] ClickMax = 4'd15;

  // stream word widths
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 8;

  // one result word
  typedef struct packed {
    logic [ClickWidth-1:0] clicks;
    logic                  single_press;
    logic                  double_press;
    logic                  long_press;
    logic                  stable_pressed;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/button_debounce_click_classifier.sv =====
// button debouncer with single, double and long press classification
//
//  channel   | direction | accept when                     | word
//  s_axis    | in        | s_axis_tvalid & s_axis_tready   | tdata[0] pin_level
//  m_axis    | out       | m_axis_tvalid & m_axis_tready   | stable, long, double, single, clicks
//  cfg       | in        | cfg_valid & cfg_ready           | cfg_index, cfg_data
//
// one input word per cycle while the output is not stalled; each word's result
// appears in the output register in the cycle after it is accepted. rst is
// synchronous and restores the register reset values and the idle debounce state.
// a stalled output holds its word; input is taken while the output register is
// empty or being drained in the same cycle. cfg is always ready.
`default_nettype none

module button_debounce_click_classifier #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [bdcc_pkg::InDataWidth-1:0]     s_axis_tdata,  // [0] pin_level, [7:1] ignored
  // output stream
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [0] stable_pressed, [1] long_press, [2] double_press, [3] single_press, [7:4] clicks
  output      logic [bdcc_pkg::OutDataWidth-1:0]    m_axis_tdata,
  // config write
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [bdcc_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [bdcc_pkg::CfgDataWidth-1:0]    cfg_data
);

  // compare width covers both timers and thresholds
  localparam int unsigned CmpWidth =
    (TIMER_BITS > bdcc_pkg::CfgDataWidth) ? TIMER_BITS : bdcc_pkg::CfgDataWidth;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  // config registers
  logic [bdcc_pkg::CfgDataWidth-1:0] debounce_ticks;
  logic [bdcc_pkg::CfgDataWidth-1:0] double_window_ticks;
  logic [bdcc_pkg::CfgDataWidth-1:0] long_press_ticks;

  // debounce and click state
  logic                            prev_raw;
  logic                            stable_state;
  logic [TIMER_BITS-1:0]           quiet_count;
  logic [TIMER_BITS-1:0]           since_press;
  logic [bdcc_pkg::ClickWidth-1:0] press_count;

  // output register
  logic              out_valid;
  bdcc_pkg::result_t out_word;

  // next values
  logic                            raw;
  logic                            pressed_now;
  logic [TIMER_BITS-1:0]           quiet_count_next;
  logic [TIMER_BITS-1:0]           since_inc;
  logic [TIMER_BITS-1:0]           since_press_next;
  logic                            take_level;
  logic                            new_press;
  logic                            stable_state_next;
  logic [bdcc_pkg::ClickWidth-1:0] count_mid;
  logic [bdcc_pkg::ClickWidth-1:0] press_count_next;
  logic                            in_window;
  logic                            window_done;
  logic                            single_f;
  bdcc_pkg::result_t               result_next;
  logic                            accept;

  // handshake
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  // per-tick update
  always_comb begin
    raw         = s_axis_tdata[0];
    pressed_now = !raw;

    // quiet counter restarts on any raw change
    if (raw != prev_raw) begin
      quiet_count_next = '0;
    end else if (quiet_count == TimerMax) begin
      quiet_count_next = quiet_count;
    end else begin
      quiet_count_next = quiet_count + 1'b1;
    end

    // time since last press, saturating
    if (since_press == TimerMax) begin
      since_inc = since_press;
    end else begin
      since_inc = since_press + 1'b1;
    end

    // accept the raw level once quiet long enough
    take_level = (CmpWidth'(quiet_count_next) > CmpWidth'(debounce_ticks)) &&
                 (pressed_now != stable_state);
    stable_state_next = take_level ? pressed_now : stable_state;
    new_press         = take_level && pressed_now;
    in_window         = CmpWidth'(since_inc) < CmpWidth'(double_window_ticks);

    // press counting
    count_mid        = press_count;
    since_press_next = since_inc;
    if (new_press) begin
      if (!in_window) begin
        count_mid = bdcc_pkg::ClickWidth'(1);
      end else if (press_count != bdcc_pkg::ClickMax) begin
        count_mid = press_count + 1'b1;
      end
      since_press_next = '0;
    end

    // lone press whose window ran out
    window_done = CmpWidth'(since_press_next) >= CmpWidth'(double_window_ticks);
    single_f    = (count_mid == bdcc_pkg::ClickWidth'(1)) && window_done;
    press_count_next = single_f ? '0 : count_mid;

    result_next.stable_pressed = stable_state_next;
    result_next.long_press     = stable_state_next &&
      (CmpWidth'(since_press_next) > CmpWidth'(long_press_ticks));
    result_next.double_press   = count_mid >= bdcc_pkg::ClickWidth'(2);
    result_next.single_press   = single_f;
    result_next.clicks         = press_count_next;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks      <= bdcc_pkg::DebounceReset;
      double_window_ticks <= bdcc_pkg::DoubleReset;
      long_press_ticks    <= bdcc_pkg::LongReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdcc_pkg::REG_DEBOUNCE: debounce_ticks      <= cfg_data;
        bdcc_pkg::REG_DOUBLE:   double_window_ticks <= cfg_data;
        bdcc_pkg::REG_LONG:     long_press_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw     <= 1'b1;
      stable_state <= 1'b0;
      quiet_count  <= '0;
      since_press  <= '0;
      press_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        prev_raw     <= raw;
        stable_state <= stable_state_next;
        quiet_count  <= quiet_count_next;
        since_press  <= since_press_next;
        press_count  <= press_count_next;
        out_valid    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/click_result_checker.sv =====
// checker for the button debouncer: tracks the pin, predicts each result word and compares
module click_result_checker
  import bdcc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  input  wire logic                     s_axis_tready,
  input  wire logic [InDataWidth-1:0]   s_axis_tdata,   // [0] pin_level, [7:1] pad
  input  wire logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [0] stable_pressed, [1] long_press, [2] double_press, [3] single_press, [7:4] clicks
  input  wire logic [OutDataWidth-1:0]  m_axis_tdata,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  output int unsigned                   pending,
  output int unsigned                   mismatches,
  output int unsigned                   words_checked
);

  localparam logic [TIMER_BITS-1:0] TimerTop = '1;

  // register copies
  logic [CfgDataWidth-1:0] debounce_lim;
  logic [CfgDataWidth-1:0] window_lim;
  logic [CfgDataWidth-1:0] long_lim;

  // debouncer and click state
  logic                  pin_last;
  logic                  level_held;
  logic [TIMER_BITS-1:0] quiet_age;
  logic [TIMER_BITS-1:0] press_age;
  logic [ClickWidth-1:0] press_total;

  result_t expected_words[$];

  task automatic report_mismatch(input string msg);
    $display("%0t word %0d: %s", $time, words_checked, msg);
    mismatches++;
  endtask

  // one pin tick through the debouncer and the click classifier
  function automatic result_t predict_tick(input logic level);
    result_t r;
    logic now_pressed;
    r = '0;
    now_pressed = ~level;
    if (level != pin_last) begin
      quiet_age = '0;
    end else if (quiet_age != TimerTop) begin
      quiet_age = quiet_age + 1'b1;
    end
    pin_last = level;
    if (press_age != TimerTop) begin
      press_age = press_age + 1'b1;
    end
    // settled level differs from the held one
    if (quiet_age > debounce_lim && now_pressed != level_held) begin
      level_held = now_pressed;
      if (level_held) begin
        if (press_age < window_lim) begin
          if (press_total != ClickMax) begin
            press_total = press_total + 1'b1;
          end
        end else begin
          press_total = ClickWidth'(1);
        end
        press_age = '0;
      end
    end
    r.stable_pressed = level_held;
    r.long_press     = level_held && (press_age > long_lim);
    r.double_press   = press_total >= 4'd2;
    // lone press whose repeat window ran out
    if (press_total == 4'd1 && press_age >= window_lim) begin
      press_total    = '0;
      r.single_press = 1'b1;
    end
    r.clicks = press_total;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      debounce_lim  = DebounceReset;
      window_lim    = DoubleReset;
      long_lim      = LongReset;
      pin_last      = 1'b1;
      level_held    = 1'b0;
      quiet_age     = '0;
      press_age     = '0;
      press_total   = '0;
      mismatches    = 0;
      words_checked = 0;
      expected_words.delete();
      pending <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_DEBOUNCE: debounce_lim = cfg_data;
          REG_DOUBLE:   window_lim = cfg_data;
          REG_LONG:     long_lim = cfg_data;
          default: ;
        endcase
      end
      // result word against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
        end else begin
          want = expected_words.pop_front();
          if (got.stable_pressed !== want.stable_pressed)
            report_mismatch($sformatf("stable_pressed %b, expected %b",
                                      got.stable_pressed, want.stable_pressed));
          if (got.long_press !== want.long_press)
            report_mismatch($sformatf("long_press %b, expected %b",
                                      got.long_press, want.long_press));
          if (got.double_press !== want.double_press)
            report_mismatch($sformatf("double_press %b, expected %b",
                                      got.double_press, want.double_press));
          if (got.single_press !== want.single_press)
            report_mismatch($sformatf("single_press %b, expected %b",
                                      got.single_press, want.single_press));
          if (got.clicks !== want.clicks)
            report_mismatch($sformatf("clicks %0d, expected %0d", got.clicks, want.clicks));
        end
        words_checked++;
      end
      // accepted pin word
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(predict_tick(s_axis_tdata[0]));
      end
      pending <= expected_words.size();
    end
  end

endmodule

// ===== test/tb_button_debounce_click_classifier.sv =====
// testbench top for the button debouncer: clock, reset, pin stimulus, register writes, verdict
module tb_button_debounce_click_classifier;
  import bdcc_pkg::*;

  localparam int unsigned TimerBits = 16;
  // index with no register behind it
  localparam logic [CfgIndexWidth-1:0] RegSpare = 2'd3;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata;   // [0] pin_level, [7:1] pad
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // [0] stable_pressed, [1] long_press, [2] double_press, [3] single_press, [7:4] clicks
  logic [OutDataWidth-1:0]  m_axis_tdata;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 1;
  int unsigned tx_idle_pct = 8;
  int unsigned rx_stall_pct = 47;

  button_debounce_click_classifier #(
    .TIMER_BITS(TimerBits)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  click_result_checker #(
    .TIMER_BITS(TimerBits)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending(pending),
    .mismatches(mismatches),
    .words_checked(words_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("button_debounce_click_classifier: mismatch");
    $finish;
  end

  // one pin tick; valid stays high if the next word follows at once
  task automatic send_tick(input logic level);
    logic [InDataWidth-2:0] pad;
    pad = ($urandom_range(3) == 0) ? (InDataWidth-1)'($urandom_range(127)) : '0;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pad, level};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // stop sending and wait for every result word
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // new register setting, written while the block is idle
  task automatic configure(input logic [CfgDataWidth-1:0] debounce,
                           input logic [CfgDataWidth-1:0] window,
                           input logic [CfgDataWidth-1:0] hold_long);
    wait_drained();
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_DOUBLE, window);
    write_reg(REG_LONG, hold_long);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // pin levels spelled as a string of 0 and 1
  task automatic pin_pattern(input string levels);
    for (int i = 0; i < levels.len(); i++) begin
      send_tick(levels[i] == "1");
    end
  endtask

  // mostly press and release with contact chatter, some random noise
  task automatic random_clicks(input int unsigned n_ticks, input int unsigned span);
    int unsigned stop_at;
    int unsigned hold;
    int unsigned gap;
    int unsigned chatter;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        hold    = $urandom_range(span, 1);
        gap     = $urandom_range(span, 1);
        chatter = $urandom_range(3);
        repeat (chatter) send_tick(1'($urandom_range(1)));
        repeat (hold) send_tick(1'b0);
        repeat (chatter) send_tick(1'($urandom_range(1)));
        repeat (gap) send_tick(1'b1);
      end else begin
        repeat ($urandom_range(8, 1)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: pin moves but never settles
    pin_pattern("1001");

    // no debounce, short window: press, repeat, long hold, lone press with single pulse
    configure(16'd0, 16'd6, 16'd2);
    pin_pattern("00110000011111100111111");

    // sender rarely idles, receiver stalls often
    configure(16'd2, 16'd30, 16'd20);
    random_clicks(150, 40);
    wait_drained();
    random_clicks(150, 40);

    // the other way round; endless window drives the count into saturation
    tx_idle_pct  = 47;
    rx_stall_pct = 8;
    configure(16'd0, 16'hFFFF, 16'd0);
    random_clicks(250, 4);

    // no idling from here on
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    configure(16'd5, 16'd0, 16'hFFFF);
    write_reg(RegSpare, 16'($urandom_range(16'hFFFF)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    random_clicks(200, 15);

    // level can never settle
    configure(16'hFFFF, 16'd12, 16'd7);
    random_clicks(80, 10);

    configure(16'd1, 16'd8, 16'd5);
    random_clicks(100, 12);

    // drain with a bound
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 2000 && pending != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d pin ticks under %0d register settings, %0d result words compared",
             ticks_sent, settings_used, words_checked);
    if (pending != 0) begin
      $display("%0d result words never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("button_debounce_click_classifier: match");
    end else begin
      $display("button_debounce_click_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ===== button_debounce_click_classifier.f =====
hdl/bdcc_pkg.sv
hdl/button_debounce_click_classifier.sv
test/click_result_checker.sv
test/tb_button_debounce_click_classifier.sv
